// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// Next-cycle implication, inactive during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

// ===== sv/fat12c_pkg.sv =====
// Shared types, constants and helper functions of the FAT12 cluster table.
// No dependencies; fat12c_if.sv, fat12c_ctrl and the top level import this package.
package fat12c_pkg;

    localparam int TABLE_BYTES = 6144;
    localparam int ROW_BYTES   = 3;
    localparam int ROWS        = TABLE_BYTES / ROW_BYTES;
    localparam int ROW_W       = 8 * ROW_BYTES;
    localparam int ROW_AW      = $clog2(ROWS);
    localparam int ENTRY_W     = 12;
    localparam int BADDR_W     = 13;
    localparam int CFG_W       = 13;

    // Byte address to row: floor(a / 3) as a multiply by (2^17 + 1) / 3
    localparam int          DIV3_SHIFT = 17;
    localparam logic [16:0] DIV3_MUL   = 17'd43691;

    localparam logic [ENTRY_W-1:0] NONE_FREE  = 12'hFF7;
    // Bytes F0 FF FF of the first entry pair, lowest byte in the low lane
    localparam logic [ROW_W-1:0]   ROW0_RESET = 24'hFFFFF0;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FIND  = 2'd2,
        KIND_LOAD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SEARCH
    } state_t;

    // One access to the row memory
    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [ROW_W-1:0]  wdata;
        logic              re;
        logic [ROW_AW-1:0] raddr;
    } mem_req_t;

    // Row that holds a byte address (valid for any 13-bit address)
    function automatic logic [11:0] byte_row(input logic [BADDR_W-1:0] addr);
        logic [29:0] prod;
        prod = {17'b0, addr} * {13'b0, DIV3_MUL};
        return prod[DIV3_SHIFT+11:DIV3_SHIFT];
    endfunction

    // Byte lane inside the row: addr - 3 * row
    function automatic logic [1:0] byte_lane(input logic [BADDR_W-1:0] addr);
        logic [11:0] q;
        logic [13:0] three_q;
        logic [13:0] diff;
        q       = byte_row(addr);
        three_q = {2'b0, q} + {1'b0, q, 1'b0};
        diff    = {1'b0, addr} - three_q;
        return diff[1:0];
    endfunction

    // Pick the even (low) or odd (high) entry of a row
    function automatic logic [ENTRY_W-1:0] entry_of(input logic [ROW_W-1:0] row,
                                                     input logic odd);
        return odd ? row[23:12] : row[11:0];
    endfunction

endpackage

// ===== sv/fat12c_if.sv =====
// Valid/ready channel interfaces for requests and responses of the FAT12 table.
// Depends on fat12c_pkg for field widths.
interface fat12c_req_if;
    import fat12c_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [ENTRY_W-1:0] cluster;
    logic [ENTRY_W-1:0] new_value;
    logic [BADDR_W-1:0] byte_addr;
    logic [7:0]         byte_data;

    modport source (output valid, kind, cluster, new_value, byte_addr, byte_data,
                    input ready);
    modport sink   (input valid, kind, cluster, new_value, byte_addr, byte_data,
                    output ready);
endinterface

interface fat12c_rsp_if;
    import fat12c_pkg::*;

    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] entry_value;
    logic               found;

    modport source (output valid, entry_value, found, input ready);
    modport sink   (input valid, entry_value, found, output ready);
endinterface

// ===== sv/fat12c_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fat12c_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 24,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fat12c_ctrl.sv =====
// Sequencer of the FAT12 table: clearing pass, row read-modify-write and free search.
// Depends on fat12c_pkg and the channel interfaces in fat12c_if.sv.
module fat12c_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [fat12c_pkg::CFG_W-1:0]       fat_bytes,
    fat12c_req_if.sink                         req,
    fat12c_rsp_if.source                       rsp,
    output fat12c_pkg::mem_req_t               mem_req,
    input  logic [fat12c_pkg::ROW_W-1:0]       rd_data
);
    import fat12c_pkg::*;

    state_t             state_reg, state_next;
    logic [ROW_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    kind_t              kind_reg, kind_next;
    logic               odd_reg, odd_next;
    logic [1:0]         lane_reg, lane_next;
    logic               in_range_reg, in_range_next;
    logic [ENTRY_W-1:0] val_reg, val_next;
    logic [7:0]         data_reg, data_next;
    logic [12:0]        idx_reg, idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [ENTRY_W-1:0] chk_idx_reg, chk_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0] entry_value_reg, entry_value_next;
    logic               found_reg, found_next;
    logic [ROW_AW-1:0]  rmw_row_reg, rmw_row_next;

    logic               accept;
    kind_t              req_kind;
    logic [11:0]        req_row;
    logic               out_free;
    logic [CFG_W-1:0]   size_sat;
    logic [13:0]        limit;
    logic [14:0]        idx_x3;
    logic               issue_ok;
    logic               hit;
    logic               search_done;
    logic               advance;
    logic               finish;
    logic [ROW_W-1:0]   row_mod;

    // Handshake and search bookkeeping
    always_comb
    begin
        accept      = req.valid && req.ready;
        req_kind    = kind_t'(req.kind);
        req_row     = byte_row(req.byte_addr);
        out_free    = !out_valid_reg || rsp.ready;
        size_sat    = (fat_bytes > CFG_W'(TABLE_BYTES)) ? CFG_W'(TABLE_BYTES) : fat_bytes;
        limit       = {size_sat, 1'b0};
        idx_x3      = {1'b0, idx_reg, 1'b0} + {2'b0, idx_reg};
        issue_ok    = !idx_reg[12] && (idx_x3 < {1'b0, limit});
        hit         = chk_valid_reg && (entry_of(rd_data, chk_idx_reg[0]) == '0);
        search_done = hit || !issue_ok;
        advance     = (state_reg == ST_SEARCH) && !search_done;
        finish      = out_free && ((state_reg == ST_MODIFY) ||
                                   ((state_reg == ST_SEARCH) && search_done));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_kind == KIND_FIND) ? ST_SEARCH : ST_MODIFY;
                end
            end
            ST_MODIFY, ST_SEARCH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Merge the request into the row that was read
    always_comb
    begin
        row_mod = rd_data;
        case (kind_reg)
            KIND_WRITE:
            begin
                row_mod = odd_reg ? {val_reg, rd_data[11:0]} : {rd_data[23:12], val_reg};
            end
            KIND_LOAD:
            begin
                case (lane_reg)
                    2'd0:    row_mod = {rd_data[23:8], data_reg};
                    2'd1:    row_mod = {rd_data[23:16], data_reg, rd_data[7:0]};
                    default: row_mod = {data_reg, rd_data[15:0]};
                endcase
            end
            default:
            begin
                row_mod = rd_data;
            end
        endcase
    end

    // Outputs: ready, memory access, datapath and result
    always_comb
    begin
        req.ready        = (state_reg == ST_IDLE);
        mem_req          = '0;
        clr_cnt_next     = clr_cnt_reg;
        kind_next        = kind_reg;
        odd_next         = odd_reg;
        lane_next        = lane_reg;
        in_range_next    = in_range_reg;
        val_next         = val_reg;
        data_next        = data_reg;
        idx_next         = idx_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        entry_value_next = entry_value_reg;
        found_next       = found_reg;
        rmw_row_next     = rmw_row_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = (clr_cnt_reg == '0) ? ROW0_RESET : '0;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                // Latch the request and, unless it is a free search, start the row read
                if (accept)
                begin
                    kind_next      = req_kind;
                    odd_next       = req.cluster[0];
                    lane_next      = byte_lane(req.byte_addr);
                    in_range_next  = (req.byte_addr < BADDR_W'(TABLE_BYTES));
                    val_next       = req.new_value;
                    data_next      = req.byte_data;
                    idx_next       = {1'b0, req.cluster};
                    chk_valid_next = 1'b0;
                    rmw_row_next   = (req_kind == KIND_LOAD) ? req_row[ROW_AW-1:0]
                                                             : req.cluster[ENTRY_W-1:1];
                    mem_req.re     = (req_kind != KIND_FIND);
                    mem_req.raddr  = (req_kind == KIND_LOAD) ? req_row[ROW_AW-1:0]
                                                             : req.cluster[ENTRY_W-1:1];
                end
            end
            ST_MODIFY:
            begin
                // Once the output slot is free, post the result and write back the row (write, or load in range)
                if (finish)
                begin
                    mem_req.we       = (kind_reg == KIND_WRITE) ||
                                       ((kind_reg == KIND_LOAD) && in_range_reg);
                    mem_req.waddr    = rmw_row_reg;
                    mem_req.wdata    = row_mod;
                    out_valid_next   = 1'b1;
                    found_next       = 1'b0;
                    entry_value_next = (kind_reg == KIND_READ) ? entry_of(rd_data, odd_reg)
                                                               : '0;
                end
            end
            ST_SEARCH:
            begin
                // Issue one entry per cycle, check the previous one
                if (advance)
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = idx_reg[ENTRY_W-1:1];
                    chk_idx_next   = idx_reg[ENTRY_W-1:0];
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                end
                if (finish)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = hit;
                    entry_value_next = hit ? chk_idx_reg : NONE_FREE;
                end
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        odd_reg         <= odd_next;
        lane_reg        <= lane_next;
        in_range_reg    <= in_range_next;
        val_reg         <= val_next;
        data_reg        <= data_next;
        idx_reg         <= idx_next;
        chk_idx_reg     <= chk_idx_next;
        entry_value_reg <= entry_value_next;
        found_reg       <= found_next;
        rmw_row_reg     <= rmw_row_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_value = entry_value_reg;
    assign rsp.found       = found_reg;

endmodule

// ===== sv/fat12_cluster_table.sv =====
// Top level of the FAT12 cluster table: size register, sequencer and row memory.
// Depends on fat12c_pkg, fat12c_if.sv, fat12c_ram, fat12c_ctrl and assert_macros.svh.
`include "assert_macros.svh"

// FAT12 allocation table held as 2048 rows of three bytes, one entry pair per row,
// in a single-port-write RAM with registered read data. After reset a clearing
// pass writes F0 FF FF to row 0 and zeros to the other rows; no request is taken
// until it ends. For read, write and raw byte load the row is read in the accept
// cycle; when the result slot is free it is merged, written back and answered.
// A free search examines one entry per cycle through the RAM read port up to the
// first free entry or the limit. One request is in work at a time; the result
// register lets the next request in while an answer still waits, but a finished
// request holds until the slot is free. The user must write fat_bytes only while
// no request is in work; the block does not enforce it.
module fat12_cluster_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [fat12c_pkg::CFG_W-1:0] cfg_wr_data,
    fat12c_req_if.sink                   req,
    fat12c_rsp_if.source                 rsp
);
    import fat12c_pkg::*;

    logic [CFG_W-1:0] fat_bytes_reg;
    mem_req_t         mem_req;
    logic [ROW_W-1:0] rd_data;

    // Hold the table size in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_bytes_reg <= CFG_W'(TABLE_BYTES);
        end
        else if (cfg_wr_en)
        begin
            fat_bytes_reg <= cfg_wr_data;
        end
    end

    fat12c_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fat_bytes (fat_bytes_reg),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    fat12c_ram #(
        .DEPTH (ROWS),
        .WIDTH (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // One request in work at a time
    `ASSERT_NEXT(a_one_in_work, req.valid && req.ready, !req.ready)
    // Write-back and row fetch never share a cycle
    `ASSERT_IMPL(a_no_rw_overlap, mem_req.we, !mem_req.re)
    // Entry and byte requests fetch their row in the accept cycle
    `ASSERT_IMPL(a_fetch_on_accept, req.valid && req.ready && req.kind != KIND_FIND,
                 mem_req.re)

endmodule
